// File: rtl/fzc_pkg.sv
package fzc_pkg;

  localparam int DataW     = 16;
  localparam int MaxSets   = 8;
  localparam int MaxRules  = 64;
  localparam int SetIdxW   = $clog2(MaxSets);
  localparam int RuleIdxW  = $clog2(MaxRules);
  localparam int RuleW     = 3 * SetIdxW;
  localparam int CountW    = 7;
  localparam int KindW     = 3;
  localparam int IndexW    = 6;
  localparam int DegW      = 16;
  localparam int SpanW     = DataW + 1;
  localparam int AreaW     = 33;
  localparam int ProdW     = DataW + AreaW;
  localparam int NumW      = ProdW + RuleIdxW;
  localparam int DenW      = AreaW + RuleIdxW;
  localparam int MDivSteps = 15;
  localparam int FDivSteps = NumW;
  localparam int StepW     = $clog2(FDivSteps);

  localparam logic [DegW-1:0] OneQ = DegW'(32768);

  localparam logic [KindW-1:0] KindLoadFirst  = 3'd0;
  localparam logic [KindW-1:0] KindLoadSecond = 3'd1;
  localparam logic [KindW-1:0] KindLoadOut    = 3'd2;
  localparam logic [KindW-1:0] KindLoadRule   = 3'd3;
  localparam logic [KindW-1:0] KindEval       = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]          kind;
    logic [IndexW-1:0]         index;
    logic                      shape;
    logic signed [DataW-1:0]   point_a;
    logic signed [DataW-1:0]   point_b;
    logic signed [DataW-1:0]   point_c;
    logic signed [DataW-1:0]   point_d;
    logic [2:0]                rule_set_first;
    logic [2:0]                rule_set_second;
    logic [2:0]                rule_set_out;
    logic signed [DataW-1:0]   value_first;
    logic signed [DataW-1:0]   value_second;
  } fzc_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] control_value;
    logic                    no_rule_fired;
  } fzc_out_t;

  typedef struct packed {
    logic load;
    logic eval_start;
    logic setup;
    logic mdiv_step;
    logic deg_calc;
    logic area_calc;
    logic prod_calc;
    logic acc;
    logic fdiv_init;
    logic fdiv_step;
    logic write_out;
  } fzc_cmd_t;

  typedef struct packed {
    logic eval_req;
    logic set_bad;
    logic deg_zero;
    logic out_free;
  } fzc_sts_t;

endpackage

// File: rtl/fzc_ram.sv
module fzc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fzc_dp.sv
module fzc_dp import fzc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fzc_in_t             in_data_i,
  input  fzc_cmd_t            cmd_i,
  input  logic [RuleW-1:0]    rule_rdata_i,
  output logic                ram_we_o,
  output logic [RuleIdxW-1:0] ram_waddr_o,
  output logic [RuleW-1:0]    ram_wdata_o,
  output fzc_sts_t            sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output fzc_out_t            out_data_o
);

  typedef struct packed {
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [DataW-1:0] c;
    logic signed [DataW-1:0] d;
  } pts_t;

  typedef struct packed {
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [DataW-1:0] c;
  } opts_t;

  typedef struct packed {
    logic             fixed;
    logic             full;
    logic [SpanW-1:0] dx;
    logic [SpanW-1:0] span;
  } mset_t;

  function automatic logic [SpanW-1:0] diff(logic signed [DataW-1:0] hi,
                                            logic signed [DataW-1:0] lo);
    logic signed [SpanW-1:0] r;
    r = SpanW'(hi) - SpanW'(lo);
    return r;
  endfunction

  function automatic mset_t member_setup(pts_t p, logic trap, logic signed [DataW-1:0] x);
    mset_t m;
    m.fixed = 1'b1;
    m.full  = 1'b0;
    m.dx    = '0;
    m.span  = SpanW'(1);
    if (!trap) begin
      if (x <= p.a) begin
        m.fixed = 1'b1;
      end else if (x <= p.b) begin
        m.fixed = 1'b0; m.dx = diff(x, p.a); m.span = diff(p.b, p.a);
      end else if (x < p.c) begin
        m.fixed = 1'b0; m.dx = diff(p.c, x); m.span = diff(p.c, p.b);
      end
    end else begin
      if (x < p.a) begin
        m.fixed = 1'b1;
      end else if (p.a != p.b && p.a < x && x <= p.b) begin
        m.fixed = 1'b0; m.dx = diff(x, p.a); m.span = diff(p.b, p.a);
      end else if (p.b <= x && x <= p.c) begin
        m.full = 1'b1;
      end else if (p.c == p.d && p.c < x) begin
        m.fixed = 1'b1;
      end else if (p.c != p.d && p.c < x && x < p.d) begin
        m.fixed = 1'b0; m.dx = diff(p.d, x); m.span = diff(p.d, p.c);
      end
    end
    return m;
  endfunction

  pts_t  first_q  [MaxSets];
  logic  first_shape_q [MaxSets];
  pts_t  second_q [MaxSets];
  logic  second_shape_q [MaxSets];
  opts_t out_q    [MaxSets];

  logic signed [DataW-1:0] x1_q, x2_q;
  logic [SetIdxW-1:0]      so_q;
  logic [SpanW-1:0]        r1_q, r2_q, sp1_q, sp2_q;
  logic [DegW-1:0]         q1_q, q2_q;
  logic                    act1_q, act2_q;
  logic [DegW-1:0]         deg_q;
  logic [2*DegW-1:0]       degsq_q;
  logic signed [AreaW-1:0] area_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [NumW-1:0]  num_q;
  logic signed [DenW-1:0]  den_q;
  logic                    fired_q;
  logic [NumW-1:0]         fq_q;
  logic [DenW-2:0]         fr_q;
  logic [DenW-1:0]         fd_q;
  logic                    fneg_q, fzero_q;
  logic                    out_valid_q;
  fzc_out_t                out_data_q;

  logic [SetIdxW-1:0] s1, s2, so, set_idx;
  logic               set_ok;
  mset_t              m1, m2;
  logic [DegW-1:0]    deg;
  opts_t              op;
  logic [DegW-1:0]    w;
  logic signed [SpanW-1:0]   ca;
  logic signed [DegW:0]      ws;
  logic signed [2*SpanW-1:0] area_full;
  logic signed [ProdW-1:0]   prod_d;
  logic [SpanW:0]     m1r, m2r;
  logic               m1ge, m2ge;
  logic [DenW-1:0]    fr2;
  logic               fge;
  logic signed [DataW-1:0] res;

  assign s1 = rule_rdata_i[SetIdxW-1:0];
  assign s2 = rule_rdata_i[2*SetIdxW-1:SetIdxW];
  assign so = rule_rdata_i[3*SetIdxW-1:2*SetIdxW];
  assign set_idx = in_data_i.index[SetIdxW-1:0];
  assign set_ok  = int'(in_data_i.index) < MaxSets;

  assign ram_we_o    = cmd_i.load && in_data_i.kind == KindLoadRule
                       && int'(in_data_i.index) < MaxRules;
  assign ram_waddr_o = in_data_i.index[RuleIdxW-1:0];
  assign ram_wdata_o = {in_data_i.rule_set_out[SetIdxW-1:0],
                        in_data_i.rule_set_second[SetIdxW-1:0],
                        in_data_i.rule_set_first[SetIdxW-1:0]};

  assign m1 = member_setup(first_q[s1], first_shape_q[s1], x1_q);
  assign m2 = member_setup(second_q[s2], second_shape_q[s2], x2_q);
  assign deg = (q1_q < q2_q) ? q1_q : q2_q;
  assign op  = out_q[so_q];

  assign m1r  = {r1_q, 1'b0};
  assign m1ge = m1r >= {1'b0, sp1_q};
  assign m2r  = {r2_q, 1'b0};
  assign m2ge = m2r >= {1'b0, sp2_q};

  // area weight deg - deg^2/2 in q1.15
  assign w         = deg_q - degsq_q[2*DegW-1:DegW];
  assign ca        = SpanW'(op.c) - SpanW'(op.a);
  assign ws        = {1'b0, w};
  assign area_full = ca * ws;
  assign prod_d    = op.b * area_q;

  assign fr2 = {fr_q, fq_q[NumW-1]};
  assign fge = fr2 >= fd_q;

  always_comb begin
    if (fzero_q) begin
      res = '0;
    end else if (fneg_q) begin
      if (fq_q > NumW'(OneQ)) begin
        res = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        res = -fq_q[DataW-1:0];
      end
    end else if (fq_q > NumW'(OneQ - 1'b1)) begin
      res = {1'b0, {(DataW-1){1'b1}}};
    end else begin
      res = fq_q[DataW-1:0];
    end
  end

  assign sts_o.eval_req = in_data_i.kind == KindEval;
  assign sts_o.set_bad  = int'(s1) >= MaxSets || int'(s2) >= MaxSets
                          || int'(so) >= MaxSets;
  assign sts_o.deg_zero = deg == '0;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && set_ok) begin
      case (in_data_i.kind)
        KindLoadFirst: begin
          first_q[set_idx] <= {in_data_i.point_a, in_data_i.point_b,
                               in_data_i.point_c, in_data_i.point_d};
          first_shape_q[set_idx] <= in_data_i.shape;
        end
        KindLoadSecond: begin
          second_q[set_idx] <= {in_data_i.point_a, in_data_i.point_b,
                                in_data_i.point_c, in_data_i.point_d};
          second_shape_q[set_idx] <= in_data_i.shape;
        end
        KindLoadOut: begin
          out_q[set_idx] <= {in_data_i.point_a, in_data_i.point_b, in_data_i.point_c};
        end
        default: ;
      endcase
    end
    if (cmd_i.eval_start) begin
      x1_q <= in_data_i.value_first;
      x2_q <= in_data_i.value_second;
    end
    if (cmd_i.setup) begin
      so_q   <= so;
      r1_q   <= m1.dx;
      sp1_q  <= m1.span;
      act1_q <= !m1.fixed && !m1.full && m1.dx != m1.span;
      q1_q   <= (m1.full || (!m1.fixed && m1.dx == m1.span)) ? OneQ : '0;
      r2_q   <= m2.dx;
      sp2_q  <= m2.span;
      act2_q <= !m2.fixed && !m2.full && m2.dx != m2.span;
      q2_q   <= (m2.full || (!m2.fixed && m2.dx == m2.span)) ? OneQ : '0;
    end
    if (cmd_i.mdiv_step) begin
      if (act1_q) begin
        r1_q <= m1ge ? SpanW'(m1r - {1'b0, sp1_q}) : m1r[SpanW-1:0];
        q1_q <= {q1_q[DegW-2:0], m1ge};
      end
      if (act2_q) begin
        r2_q <= m2ge ? SpanW'(m2r - {1'b0, sp2_q}) : m2r[SpanW-1:0];
        q2_q <= {q2_q[DegW-2:0], m2ge};
      end
    end
    if (cmd_i.deg_calc) begin
      deg_q   <= deg;
      degsq_q <= deg * deg;
    end
    if (cmd_i.area_calc) begin
      area_q <= area_full[AreaW-1:0];
    end
    if (cmd_i.prod_calc) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fdiv_init) begin
      fneg_q  <= num_q[NumW-1] ^ den_q[DenW-1];
      fzero_q <= den_q == '0;
      fq_q    <= num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
      fd_q    <= den_q[DenW-1] ? DenW'(-den_q) : DenW'(den_q);
      fr_q    <= '0;
    end
    if (cmd_i.fdiv_step) begin
      fr_q <= fge ? (DenW-1)'(fr2 - fd_q) : fr2[DenW-2:0];
      fq_q <= {fq_q[NumW-2:0], fge};
    end
    if (cmd_i.write_out) begin
      out_data_q.control_value <= res;
      out_data_q.no_rule_fired <= !fired_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= '0;
      den_q       <= '0;
      fired_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval_start) begin
        num_q   <= '0;
        den_q   <= '0;
        fired_q <= 1'b0;
      end else if (cmd_i.acc) begin
        num_q <= num_q + NumW'(prod_q);
        den_q <= den_q + DenW'(area_q);
      end
      if (cmd_i.deg_calc) begin
        fired_q <= 1'b1;
      end
      if (cmd_i.write_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/fzc_ctrl.sv
module fzc_ctrl import fzc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,
  input  fzc_sts_t            sts_i,
  output fzc_cmd_t            cmd_o,
  output logic [RuleIdxW-1:0] ram_raddr_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_MDIV  = 4'd3;
  localparam logic [3:0] S_DEG   = 4'd4;
  localparam logic [3:0] S_AREA  = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_FINIT = 4'd8;
  localparam logic [3:0] S_FDIV  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] rule_idx_q, rule_idx_d;
  logic [CountW-1:0] n_q, n_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [CountW-1:0] rule_count_q;
  logic [CountW-1:0] idx_inc;

  assign idx_inc     = CountW'(rule_idx_q + 1'b1);
  assign ram_raddr_o = rule_idx_q[RuleIdxW-1:0];
  assign in_stall_o  = state_q != S_IDLE;

  always_comb begin
    state_d    = state_q;
    rule_idx_d = rule_idx_q;
    n_d        = n_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.eval_req) begin
            cmd_o.eval_start = 1'b1;
            rule_idx_d = '0;
            n_d = (rule_count_q > CountW'(MaxRules)) ? CountW'(MaxRules) : rule_count_q;
            state_d = (n_d == '0) ? S_FINIT : S_READ;
          end
        end
      end
      S_READ: state_d = S_SETUP;
      S_SETUP: begin
        if (sts_i.set_bad) begin
          rule_idx_d = idx_inc;
          state_d = (idx_inc == n_q) ? S_FINIT : S_READ;
        end else begin
          cmd_o.setup = 1'b1;
          cnt_d = '0;
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd_o.mdiv_step = 1'b1;
        cnt_d = StepW'(cnt_q + 1'b1);
        if (cnt_q == StepW'(MDivSteps - 1)) begin
          state_d = S_DEG;
        end
      end
      S_DEG: begin
        if (sts_i.deg_zero) begin
          rule_idx_d = idx_inc;
          state_d = (idx_inc == n_q) ? S_FINIT : S_READ;
        end else begin
          cmd_o.deg_calc = 1'b1;
          state_d = S_AREA;
        end
      end
      S_AREA: begin
        cmd_o.area_calc = 1'b1;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod_calc = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        rule_idx_d = idx_inc;
        state_d = (idx_inc == n_q) ? S_FINIT : S_READ;
      end
      S_FINIT: begin
        cmd_o.fdiv_init = 1'b1;
        cnt_d = '0;
        state_d = S_FDIV;
      end
      S_FDIV: begin
        cmd_o.fdiv_step = 1'b1;
        cnt_d = StepW'(cnt_q + 1'b1);
        if (cnt_q == StepW'(FDivSteps - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rule_idx_q   <= '0;
      n_q          <= '0;
      cnt_q        <= '0;
      rule_count_q <= '0;
    end else begin
      state_q    <= state_d;
      rule_idx_q <= rule_idx_d;
      n_q        <= n_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        rule_count_q <= cfg_wdata_i;
      end
    end
  end

  a_rule_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> rule_idx_q < n_q && int'(n_q) <= MaxRules)
    else $error("rule index past rule count");

  a_mdiv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MDIV |-> int'(cnt_q) < MDivSteps)
    else $error("membership divide overran");

  a_fdiv_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINIT |=> state_q == S_FDIV && cnt_q == '0)
    else $error("final divide did not start");

  a_done_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_out |-> $past(state_q) == S_FDIV || $past(state_q) == S_DONE)
    else $error("result written without divide");

endmodule

// File: rtl/two_input_fuzzy_controller.sv
// channel  | handshake             | payload
// in       | in_valid_i/in_stall_o | in_data_i (fzc_in_t)
// out      | out_valid_o/out_stall_i | out_data_o (fzc_out_t)
// cfg      | cfg_we_i              | cfg_wdata_i (rule_count)
//
// load requests are accepted in idle, which the controller does not leave for them
// evaluate: accept, then per rule read, setup (a bad set skips the rule), 15-step membership
//   divides, degree (a zero degree skips the rule), area, product, accumulate; then the 55-step
//   signed result divide and the output write, which waits while the output is stalled
// one request in flight; a finished result waits in the output register
// reset clears control state and rule_count; set and rule tables hold garbage until loaded
module two_input_fuzzy_controller import fzc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fzc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fzc_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i
);

  fzc_cmd_t            cmd;
  fzc_sts_t            sts;
  logic [RuleIdxW-1:0] raddr, waddr;
  logic [RuleW-1:0]    rdata, wdata;
  logic                we;

  fzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .ram_raddr_o (raddr)
  );

  fzc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .cmd_i        (cmd),
    .rule_rdata_i (rdata),
    .ram_we_o     (we),
    .ram_waddr_o  (waddr),
    .ram_wdata_o  (wdata),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  fzc_ram #(
    .Width (RuleW),
    .Depth (MaxRules)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
